// ----- hdl/yaw_pitch_to_direction_assert.svh -----
// Assertion macros shared by the yaw/pitch direction block.
`ifndef YAW_PITCH_TO_DIRECTION_ASSERT_SVH
`define YAW_PITCH_TO_DIRECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define YPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ypd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define YPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ypd assertion failed");

`endif

// ----- hdl/ypd_pkg.sv -----
// Shared constants, types and the arctangent table for the direction block.
package ypd_pkg;

    // Field formats
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int OUT_FRAC_BITS   = 15;
    localparam int YAW_W           = 16;
    localparam int PITCH_W         = 15;
    localparam int DIR_W           = 16;

    // Angle range: one turn and the pitch limit in input units
    localparam int FULL  = 360 << ANGLE_FRAC_BITS;
    localparam int LIM   = 89 << ANGLE_FRAC_BITS;
    localparam int RES_W = $clog2(FULL);
    localparam int MAG_W = $clog2(LIM + 1);

    // Conversion to binary angle: FULL = FULL_ODD * 2^FULL_TZ
    localparam int     ANG_W     = 32;
    localparam int     FULL_TZ   = ANGLE_FRAC_BITS + 3;
    localparam int     FULL_ODD  = 45;
    localparam longint TURN_SPAN = longint'(1) << (ANG_W - FULL_TZ);
    localparam longint TURN_QUO  = TURN_SPAN / FULL_ODD;
    localparam longint TURN_REM  = TURN_SPAN % FULL_ODD;
    localparam longint TURN_HALF = longint'(FULL / 2) >> FULL_TZ;
    localparam int     QUO_W     = $clog2(TURN_QUO + 1);
    localparam longint FRAC_MAX  = TURN_REM * longint'(FULL - 1) + TURN_HALF;
    localparam int     FRAC_W    = $clog2(FRAC_MAX + 1);
    localparam int     RECIP_SH  = 26;
    localparam longint RECIP     = ((longint'(1) << RECIP_SH) + FULL_ODD - 1) / FULL_ODD;
    localparam int     RECIP_W   = $clog2(RECIP + 1);
    localparam int     LO_W      = FRAC_W + RECIP_W - RECIP_SH;

    // Rotation chain
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // Vector and residual angle of one rotation lane (Q2.30 and binary angle)
    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_vec;

    // Data handed from cell to cell: yaw lane, pitch lane, yaw half-turn mark
    typedef struct packed {
        logic yaw_flip;
        t_vec yaw;
        t_vec pit;
    } t_cell_data;

    // Arctangent of 2^-idx in binary angle units
    function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [ANG_W-1:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ----- hdl/yaw_pitch_to_direction.sv -----
// Top level: yaw and pitch angles in, unit direction vector out.
//
// Input stream: i_s_tdata carries yaw (signed, 1/64 degree) and pitch (signed,
// 1/64 degree). Yaw wraps modulo 360 degrees, pitch is clamped to +/-89 degrees.
// Output stream: o_m_tdata carries x = cos(yaw)cos(pitch), y = sin(pitch) and
// z = sin(yaw)cos(pitch), each signed Q1.15, +1.0 saturating to 32767.
// Throughput: one item per cycle while the receiver does not stall; every stage
// is a register stage. Path of an item from input to o_m_tvalid: four front-end
// stages (wrap/clamp, two multiply stages, angle assembly), a row of 30 rotation
// cells, one per CORDIC step, and the sign-fix, product and rounding stages, the
// last of which is the output register.
// All stages advance together whenever the output register is empty or being
// taken; while the receiver stalls with a result waiting, the whole pipe holds
// and o_s_tready is low. A transfer on the input is taken in the same cycle the
// output transfer completes. Reset clears every valid flag; no state is kept
// between items.
module yaw_pitch_to_direction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] yaw_angle, [30:16] pitch_angle, [31] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
);

    localparam int STEPS = ypd_pkg::CORDIC_STEPS;
    localparam int YAW_W = ypd_pkg::YAW_W;
    localparam int PIT_W = ypd_pkg::PITCH_W;
    localparam int DIR_W = ypd_pkg::DIR_W;

    logic                      w_en;
    logic                      w_out_vld;
    logic [DIR_W-1:0]          w_dir_x;
    logic [DIR_W-1:0]          w_dir_y;
    logic [DIR_W-1:0]          w_dir_z;
    logic                      w_cv [0:STEPS];
    ypd_pkg::t_cell_data       w_cd [0:STEPS];

    // Pipe advance: output register free or being taken
    assign w_en       = !w_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    // Wrap, clamp and binary angle conversion
    ypd_angle_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_yaw   (i_s_tdata[YAW_W-1:0]),
        .i_pitch (i_s_tdata[YAW_W+PIT_W-1:YAW_W]),
        .o_vld   (w_cv[0]),
        .o_d     (w_cd[0])
    );

    // Row of rotation cells, one per step
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        ypd_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_step  (ypd_pkg::STEP_W'(g)),
            .i_vld   (w_cv[g]),
            .i_d     (w_cd[g]),
            .o_vld   (w_cv[g+1]),
            .o_d     (w_cd[g+1])
        );
    end

    // Sign fix, products and output register
    ypd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_cv[STEPS]),
        .i_d     (w_cd[STEPS]),
        .o_vld   (w_out_vld),
        .o_dir_x (w_dir_x),
        .o_dir_y (w_dir_y),
        .o_dir_z (w_dir_z)
    );

    assign o_m_tvalid = w_out_vld;
    assign o_m_tdata  = {w_dir_z, w_dir_y, w_dir_x};

endmodule

// ----- hdl/ypd_cordic_cell.sv -----
// One rotation step for both the yaw and the pitch lane.
module ypd_cordic_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [ypd_pkg::STEP_W-1:0]     i_step,
    input  logic                           i_vld,
    input  ypd_pkg::t_cell_data            i_d,
    output logic                           o_vld,
    output ypd_pkg::t_cell_data            o_d
);

    logic                r_vld;
    ypd_pkg::t_cell_data r_d;
    ypd_pkg::t_cell_data n_d;

    // Rotate toward zero residual; shifts are floor shifts
    function automatic ypd_pkg::t_vec rot(input ypd_pkg::t_vec v,
                                          input logic [ypd_pkg::STEP_W-1:0] s);
        logic signed [ypd_pkg::ANG_W-1:0] dx;
        logic signed [ypd_pkg::ANG_W-1:0] dy;
        logic signed [ypd_pkg::ANG_W-1:0] a;
        ypd_pkg::t_vec                    r;
        dx = $signed(v.y) >>> s;
        dy = $signed(v.x) >>> s;
        a  = $signed(ypd_pkg::atan_turn(s));
        if (!v.z[ypd_pkg::ANG_W-1]) begin
            r.x = $signed(v.x) - dx;
            r.y = $signed(v.y) + dy;
            r.z = $signed(v.z) - a;
        end else begin
            r.x = $signed(v.x) + dx;
            r.y = $signed(v.y) - dy;
            r.z = $signed(v.z) + a;
        end
        return r;
    endfunction

    // Next step values
    always_comb begin
        n_d          = i_d;
        n_d.yaw      = rot(i_d.yaw, i_step);
        n_d.pit      = rot(i_d.pit, i_step);
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

// ----- hdl/ypd_angle_conv.sv -----
// Front end: yaw wrap, pitch clamp and conversion to binary angles.
`include "yaw_pitch_to_direction_assert.svh"

module ypd_angle_conv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [ypd_pkg::YAW_W-1:0]       i_yaw,
    input  logic [ypd_pkg::PITCH_W-1:0]     i_pitch,
    output logic                            o_vld,
    output ypd_pkg::t_cell_data             o_d
);

    localparam int EXT_W  = ypd_pkg::YAW_W + 2;
    localparam int POS_W  = ypd_pkg::YAW_W + 1;
    localparam int ABS_W  = ypd_pkg::PITCH_W + 1;
    localparam int RES_W  = ypd_pkg::RES_W;
    localparam int MAG_W  = ypd_pkg::MAG_W;
    localparam int ANG_W  = ypd_pkg::ANG_W;
    localparam int FRAC_W = ypd_pkg::FRAC_W;
    localparam int LO_W   = ypd_pkg::LO_W;
    localparam int HIY_W  = ypd_pkg::QUO_W + RES_W;
    localparam int HIP_W  = ypd_pkg::QUO_W + MAG_W;
    localparam int LOP_W  = FRAC_W + ypd_pkg::RECIP_W;

    // Stage 1: yaw residue, clamped pitch magnitude
    logic [EXT_W-1:0] w_yaw_ext;
    logic [POS_W-1:0] w_yaw_pos;
    logic [RES_W-1:0] n1_yaw_res;
    logic             w_pneg;
    logic [ABS_W-1:0] w_pabs;
    logic [MAG_W-1:0] n1_pmag;
    logic             r1_vld;
    logic [RES_W-1:0] r1_yaw_res;
    logic [MAG_W-1:0] r1_pmag;
    logic             r1_pneg;

    // Stage 2: integer part of the quotient, remainder term
    logic [HIY_W-1:0]  w_yaw_hi;
    logic [HIP_W-1:0]  w_pit_hi;
    logic [FRAC_W-1:0] w_yaw_v;
    logic [FRAC_W-1:0] w_pit_v;
    logic              r2_vld;
    logic [ANG_W-1:0]  r2_yaw_hi;
    logic [ANG_W-1:0]  r2_pit_hi;
    logic [FRAC_W-1:0] r2_yaw_v;
    logic [FRAC_W-1:0] r2_pit_v;
    logic              r2_pneg;

    // Stage 3: remainder term divided by the odd factor
    logic [LOP_W-1:0] w_yaw_lo;
    logic [LOP_W-1:0] w_pit_lo;
    logic             r3_vld;
    logic [ANG_W-1:0] r3_yaw_hi;
    logic [ANG_W-1:0] r3_pit_hi;
    logic [LO_W-1:0]  r3_yaw_lo;
    logic [LO_W-1:0]  r3_pit_lo;
    logic             r3_pneg;

    // Stage 4: binary angles and start vectors
    logic [ANG_W-1:0]    w_yaw_t;
    logic [ANG_W-1:0]    w_pit_t;
    ypd_pkg::t_cell_data n4_d;
    logic                r4_vld;
    ypd_pkg::t_cell_data r4_d;

    // Yaw modulo one turn: bias to positive, then take off zero to three turns
    always_comb begin
        w_yaw_ext = {{2{i_yaw[ypd_pkg::YAW_W-1]}}, i_yaw} + EXT_W'(2 * ypd_pkg::FULL);
        w_yaw_pos = w_yaw_ext[POS_W-1:0];
        if (w_yaw_pos >= POS_W'(3 * ypd_pkg::FULL)) begin
            n1_yaw_res = RES_W'(w_yaw_pos - POS_W'(3 * ypd_pkg::FULL));
        end else if (w_yaw_pos >= POS_W'(2 * ypd_pkg::FULL)) begin
            n1_yaw_res = RES_W'(w_yaw_pos - POS_W'(2 * ypd_pkg::FULL));
        end else if (w_yaw_pos >= POS_W'(ypd_pkg::FULL)) begin
            n1_yaw_res = RES_W'(w_yaw_pos - POS_W'(ypd_pkg::FULL));
        end else begin
            n1_yaw_res = RES_W'(w_yaw_pos);
        end
    end

    // Pitch sign and clamped magnitude
    always_comb begin
        w_pneg = i_pitch[ypd_pkg::PITCH_W-1];
        if (w_pneg) begin
            w_pabs = ABS_W'(0) - {i_pitch[ypd_pkg::PITCH_W-1], i_pitch};
        end else begin
            w_pabs = {1'b0, i_pitch};
        end
        if (w_pabs > ABS_W'(ypd_pkg::LIM)) begin
            n1_pmag = MAG_W'(ypd_pkg::LIM);
        end else begin
            n1_pmag = w_pabs[MAG_W-1:0];
        end
    end

    // r * 2^32 / FULL = r * QUO + (r * REM + HALF) / ODD
    assign w_yaw_hi = HIY_W'(r1_yaw_res) * HIY_W'(ypd_pkg::TURN_QUO);
    assign w_pit_hi = HIP_W'(r1_pmag) * HIP_W'(ypd_pkg::TURN_QUO);
    assign w_yaw_v  = FRAC_W'(r1_yaw_res) * FRAC_W'(ypd_pkg::TURN_REM)
                    + FRAC_W'(ypd_pkg::TURN_HALF);
    assign w_pit_v  = FRAC_W'(r1_pmag) * FRAC_W'(ypd_pkg::TURN_REM)
                    + FRAC_W'(ypd_pkg::TURN_HALF);

    // Exact division by the odd factor through a scaled reciprocal
    assign w_yaw_lo = LOP_W'(r2_yaw_v) * LOP_W'(ypd_pkg::RECIP);
    assign w_pit_lo = LOP_W'(r2_pit_v) * LOP_W'(ypd_pkg::RECIP);

    // Final angles; yaw in the back half-plane is turned by a half turn
    always_comb begin
        w_yaw_t = r3_yaw_hi + ANG_W'(r3_yaw_lo);
        w_pit_t = r3_pit_hi + ANG_W'(r3_pit_lo);
        n4_d.yaw_flip = w_yaw_t[ANG_W-1] ^ w_yaw_t[ANG_W-2];
        n4_d.yaw.x    = ypd_pkg::CORDIC_GAIN;
        n4_d.yaw.y    = '0;
        n4_d.yaw.z    = $signed({w_yaw_t[ANG_W-2], w_yaw_t[ANG_W-2:0]});
        n4_d.pit.x    = ypd_pkg::CORDIC_GAIN;
        n4_d.pit.y    = '0;
        if (r3_pneg) begin
            n4_d.pit.z = $signed(ANG_W'(0) - w_pit_t);
        end else begin
            n4_d.pit.z = $signed(w_pit_t);
        end
    end

    // Valid flags of all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // Payload of all stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_yaw_res <= n1_yaw_res;
            r1_pmag    <= n1_pmag;
            r1_pneg    <= w_pneg;
            r2_yaw_hi  <= w_yaw_hi[ANG_W-1:0];
            r2_pit_hi  <= ANG_W'(w_pit_hi);
            r2_yaw_v   <= w_yaw_v;
            r2_pit_v   <= w_pit_v;
            r2_pneg    <= r1_pneg;
            r3_yaw_hi  <= r2_yaw_hi;
            r3_pit_hi  <= r2_pit_hi;
            r3_yaw_lo  <= w_yaw_lo[LOP_W-1:ypd_pkg::RECIP_SH];
            r3_pit_lo  <= w_pit_lo[LOP_W-1:ypd_pkg::RECIP_SH];
            r3_pneg    <= r2_pneg;
            r4_d       <= n4_d;
        end
    end

    assign o_vld = r4_vld;
    assign o_d   = r4_d;

    // Checks
    `YPD_ASSERT_IMPL(a_yaw_res_range, i_clk, i_rst_n, r1_vld, r1_yaw_res < RES_W'(ypd_pkg::FULL))
    `YPD_ASSERT_IMPL(a_pitch_clamped, i_clk, i_rst_n, r1_vld, r1_pmag <= MAG_W'(ypd_pkg::LIM))
    `YPD_ASSERT_IMPL(a_pitch_front_half, i_clk, i_rst_n, r3_vld, w_pit_t < 32'h4000_0000)
    `YPD_ASSERT_NEXT(a_yaw_z_range, i_clk, i_rst_n, i_en && r3_vld,
                     r4_d.yaw.z[ANG_W-1] == r4_d.yaw.z[ANG_W-2])

endmodule

// ----- hdl/ypd_out_stage.sv -----
// Back end: sign fix, products and rounding to Q1.15 with saturation.
module ypd_out_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  ypd_pkg::t_cell_data             i_d,
    output logic                            o_vld,
    output logic [ypd_pkg::DIR_W-1:0]       o_dir_x,
    output logic [ypd_pkg::DIR_W-1:0]       o_dir_y,
    output logic [ypd_pkg::DIR_W-1:0]       o_dir_z
);

    localparam int ANG_W  = ypd_pkg::ANG_W;
    localparam int PROD_W = 2 * ANG_W;
    localparam int SH     = 60 - ypd_pkg::OUT_FRAC_BITS;
    localparam int RND_W  = PROD_W - SH;
    localparam logic signed [RND_W-1:0] R_HI = RND_W'((1 << ypd_pkg::OUT_FRAC_BITS) - 1);
    localparam logic signed [RND_W-1:0] R_LO = RND_W'(-(1 << ypd_pkg::OUT_FRAC_BITS));

    // Sign fix stage
    logic                      r_f_vld;
    logic signed [ANG_W-1:0]   r_f_cy;
    logic signed [ANG_W-1:0]   r_f_sy;
    logic signed [ANG_W-1:0]   r_f_cp;
    logic signed [ANG_W-1:0]   r_f_sp;

    // Product stage
    logic signed [PROD_W-1:0]  w_px;
    logic signed [PROD_W-1:0]  w_pz;
    logic                      r_m_vld;
    logic signed [PROD_W-1:0]  r_m_px;
    logic signed [PROD_W-1:0]  r_m_pz;
    logic signed [ANG_W-1:0]   r_m_sp;

    // Output register
    logic                      r_o_vld;
    logic [ypd_pkg::DIR_W-1:0] r_o_x;
    logic [ypd_pkg::DIR_W-1:0] r_o_y;
    logic [ypd_pkg::DIR_W-1:0] r_o_z;

    // Q60 to output format: round half up, saturate, keep the field bits
    function automatic logic [ypd_pkg::DIR_W-1:0] q60_out(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] sum;
        logic signed [RND_W-1:0]  r;
        logic signed [RND_W-1:0]  s;
        sum = v + (PROD_W'(1) <<< (SH - 1));
        r   = $signed(sum[PROD_W-1:SH]);
        if (r > R_HI) begin
            s = R_HI;
        end else if (r < R_LO) begin
            s = R_LO;
        end else begin
            s = r;
        end
        return s[ypd_pkg::DIR_W-1:0];
    endfunction

    assign w_px = r_f_cy * r_f_cp;
    assign w_pz = r_f_sy * r_f_cp;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= i_vld;
            r_m_vld <= r_f_vld;
            r_o_vld <= r_m_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_d.yaw_flip) begin
                r_f_cy <= -$signed(i_d.yaw.x);
                r_f_sy <= -$signed(i_d.yaw.y);
            end else begin
                r_f_cy <= i_d.yaw.x;
                r_f_sy <= i_d.yaw.y;
            end
            r_f_cp <= i_d.pit.x;
            r_f_sp <= i_d.pit.y;
            r_m_px <= w_px;
            r_m_pz <= w_pz;
            r_m_sp <= r_f_sp;
            r_o_x  <= q60_out(r_m_px);
            r_o_y  <= q60_out($signed({{2{r_m_sp[ANG_W-1]}}, r_m_sp, 30'd0}));
            r_o_z  <= q60_out(r_m_pz);
        end
    end

    assign o_vld   = r_o_vld;
    assign o_dir_x = r_o_x;
    assign o_dir_y = r_o_y;
    assign o_dir_z = r_o_z;

endmodule

// ----- tb/yaw_pitch_to_direction_tb.sv -----
// Self-checking testbench for the yaw/pitch to direction vector block.
module yaw_pitch_to_direction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Angle and output scaling used by the predictor
    localparam longint TURN_FULL   = longint'(360) << ypd_pkg::ANGLE_FRAC_BITS;
    localparam longint PITCH_LIMIT = longint'(89) << ypd_pkg::ANGLE_FRAC_BITS;
    localparam longint VEC_GAIN    = 64'sd652032874;
    localparam int     ROT_STEPS   = 30;
    localparam int     ROUND_SH    = 60 - ypd_pkg::OUT_FRAC_BITS;
    localparam longint OUT_HI      = (longint'(1) << ypd_pkg::OUT_FRAC_BITS) - 1;
    localparam longint OUT_LO      = -(longint'(1) << ypd_pkg::OUT_FRAC_BITS);
    localparam int     DEG90       = 90 << ypd_pkg::ANGLE_FRAC_BITS;
    localparam int     REPORT_MAX  = 10;

    // Arctangent of 2^-i in binary angle units (2^32 per turn)
    localparam logic [31:0] ARCTAN_STEP [0:ROT_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // One direction result, packed in the same order as o_m_tdata
    typedef struct packed {
        logic signed [ypd_pkg::DIR_W-1:0] z;
        logic signed [ypd_pkg::DIR_W-1:0] y;
        logic signed [ypd_pkg::DIR_W-1:0] x;
    } t_dir;

    typedef struct {
        t_dir        dir;
        logic [31:0] angles;
    } t_pending;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // [15:0] yaw_angle, [30:16] pitch_angle, [31] zero
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z

    t_pending pending_dirs[$];
    int       error_count;
    bit       send_idle_on;
    bit       recv_stall_on;

    yaw_pitch_to_direction u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // CORDIC rotation: binary angle -> cosine and sine in Q30
    function automatic void rotate_unit(input logic [31:0] turns,
                                        output longint cos_q30, output longint sin_q30);
        logic [31:0] a;
        bit          flip;
        longint      vx, vy, vz, dx, dy;
        a    = turns;
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip) a = a + 32'h80000000;
        vz = longint'($signed(a));
        vx = VEC_GAIN;
        vy = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vz >= 0) begin
                vx = vx - dx;
                vy = vy + dy;
                vz = vz - longint'({32'h0, ARCTAN_STEP[i]});
            end else begin
                vx = vx + dx;
                vy = vy - dy;
                vz = vz + longint'({32'h0, ARCTAN_STEP[i]});
            end
        end
        cos_q30 = flip ? -vx : vx;
        sin_q30 = flip ? -vy : vy;
    endfunction

    // Non-negative angle in input units -> binary angle, rounded half up
    function automatic logic [31:0] angle_to_turns(input longint mag);
        logic [63:0] num;
        num = ($unsigned(mag) << 32) + 64'(TURN_FULL / 2);
        return 32'(num / 64'(TURN_FULL));
    endfunction

    // Q60 -> output format, rounded half up and saturated
    function automatic logic [ypd_pkg::DIR_W-1:0] round_q60(input longint v);
        longint r;
        r = (v + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
        if (r > OUT_HI) r = OUT_HI;
        if (r < OUT_LO) r = OUT_LO;
        return r[ypd_pkg::DIR_W-1:0];
    endfunction

    function automatic t_dir predict_direction(
        input logic signed [ypd_pkg::YAW_W-1:0]   yaw,
        input logic signed [ypd_pkg::PITCH_W-1:0] pitch);
        longint      yw, pt, rem, cy, sy, cp, sp;
        logic [31:0] ya, pa;
        t_dir        d;
        yw  = longint'(yaw);
        pt  = longint'(pitch);
        // yaw wraps into one turn
        rem = yw % TURN_FULL;
        if (rem < 0) rem = rem + TURN_FULL;
        ya = angle_to_turns(rem);
        // pitch clamps to the limit, magnitude rounded then sign restored
        if (pt > PITCH_LIMIT) pt = PITCH_LIMIT;
        if (pt < -PITCH_LIMIT) pt = -PITCH_LIMIT;
        if (pt < 0) pa = 32'd0 - angle_to_turns(-pt);
        else        pa = angle_to_turns(pt);
        rotate_unit(ya, cy, sy);
        rotate_unit(pa, cp, sp);
        d.x = round_q60(cy * cp);
        d.y = round_q60(sp * (longint'(1) << 30));
        d.z = round_q60(sy * cp);
        return d;
    endfunction

    // ---------------------------------------------------------------
    // Shared helpers
    // ---------------------------------------------------------------

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_idle_len(input bit on);
        int roll;
        if (!on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one angle pair and wait for its transfer
    task automatic send_angles(input int yaw, input int pitch);
        int                                  gap;
        logic signed [ypd_pkg::YAW_W-1:0]    yv;
        logic signed [ypd_pkg::PITCH_W-1:0]  pv;
        t_pending                            p;
        yv  = yaw[ypd_pkg::YAW_W-1:0];
        pv  = pitch[ypd_pkg::PITCH_W-1:0];
        gap = pick_idle_len(send_idle_on);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, pv, yv};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        p.dir    = predict_direction(yv, pv);
        p.angles = {1'b0, pv, yv};
        pending_dirs.push_back(p);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls and checking
    // ---------------------------------------------------------------
    initial begin
        int       stall_left;
        int       n;
        t_dir     got;
        t_pending want;
        stall_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                got = o_m_tdata;
                if (pending_dirs.size() == 0) begin
                    log_failure($sformatf("unexpected result x=%0d y=%0d z=%0d",
                                          got.x, got.y, got.z));
                end else begin
                    want = pending_dirs.pop_front();
                    if (got.x !== want.dir.x || got.y !== want.dir.y ||
                        got.z !== want.dir.z)
                        log_failure($sformatf(
                            "yaw=%0d pitch=%0d exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                            $signed(want.angles[15:0]), $signed(want.angles[30:16]),
                            want.dir.x, want.dir.y, want.dir.z, got.x, got.y, got.z));
                end
            end
            // next cycle's ready
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                n = pick_idle_len(recv_stall_on);
                if (n == 0) begin
                    i_m_tready <= 1'b1;
                end else begin
                    stall_left = n - 1;
                    i_m_tready <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Axis angles, field extremes and the pitch limit itself
    task automatic test_axis_extremes();
        int yaws   [22] = '{0, 5760, 11520, 17280, -5760, 32767, -32768, 23039,
                            -23040, 0, 0, 0, 0, 0, 0, 0, 0, 2880, 1, -1, 11520, 17279};
        int pitches[22] = '{0, 0, 0, 0, 0, 0, 0, 16383,
                            -16384, 5696, -5696, 5697, -5697, 5760, -5760, 16383,
                            -16384, 2880, 1, -1, 5696, -5695};
        for (int i = 0; i < 22; i++) send_angles(yaws[i], pitches[i]);
    endtask

    // Pitch around and beyond the clamp, either sign
    task automatic test_pitch_clamp(input int count);
        int pitch;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 2))
                0:       pitch = int'(PITCH_LIMIT) + $urandom_range(0, 8) - 4;
                1:       pitch = int'(PITCH_LIMIT) + $urandom_range(0, 16383 - 5696);
                default: pitch = $urandom_range(0, 16383);
            endcase
            if ($urandom_range(0, 1)) pitch = -pitch - $urandom_range(0, 1);
            send_angles($urandom_range(0, 23039), pitch);
        end
    endtask

    // Yaw outside one turn so it must wrap
    task automatic test_yaw_wrap(input int count);
        int yaw;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1)) yaw = $urandom_range(23040, 32767);
            else                      yaw = -int'($urandom_range(23041, 32768));
            send_angles(yaw, $urandom_range(0, 11519) - 5760);
        end
    endtask

    // Yaw close to every quarter turn, among them those where the half-turn fold switches
    task automatic test_quadrant_edges(input int count);
        int yaw;
        int pitch;
        for (int i = 0; i < count; i++) begin
            yaw = (int'($urandom_range(0, 10)) - 5) * DEG90 + int'($urandom_range(0, 6)) - 3;
            case ($urandom_range(0, 2))
                0:       pitch = int'($urandom_range(0, 6)) - 3;
                1:       pitch = int'(PITCH_LIMIT) - int'($urandom_range(0, 3));
                default: pitch = int'($urandom_range(0, 4)) - int'(PITCH_LIMIT) - 2;
            endcase
            send_angles(yaw, pitch);
        end
    endtask

    // Any bit pattern on either field, or values in the normal range
    task automatic test_random_angles(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0)
                send_angles($urandom_range(0, 46079) - 23040,
                            $urandom_range(0, 23039) - 11520);
            else
                send_angles($urandom, $urandom);
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        int waited;
        error_count   = 0;
        send_idle_on  = 1'b1;
        recv_stall_on = 1'b1;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_axis_extremes();
        test_pitch_clamp(150);
        test_yaw_wrap(150);
        test_quadrant_edges(200);
        test_random_angles(800);

        // full-rate stretch, neither side idles
        send_idle_on  = 1'b0;
        recv_stall_on = 1'b0;
        test_random_angles(250);
        send_idle_on  = 1'b1;
        recv_stall_on = 1'b1;
        test_random_angles(100);

        i_s_tvalid <= 1'b0;

        // drain the pipe, then watch for stray results
        waited = 0;
        while (pending_dirs.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_dirs.size() != 0)
            log_failure($sformatf("%0d results never arrived", pending_dirs.size()));

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- yaw_pitch_to_direction.f -----
+incdir+hdl
hdl/ypd_pkg.sv
hdl/ypd_cordic_cell.sv
hdl/ypd_angle_conv.sv
hdl/ypd_out_stage.sv
hdl/yaw_pitch_to_direction.sv
tb/yaw_pitch_to_direction_tb.sv
